// File: design/tcdmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcdmr_pkg
// Shared types, constants and the colour quantizer for the dirty map renderer.
// ----------------------------------------------------------------------------
package tcdmr_pkg;

  // Default dirty map depth
  localparam int MAX_CELLS_DEF = 4096;

  // Widths fixed by the item fields
  localparam int COLS_W   = 8;
  localparam int ROWS_W   = 7;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 6;
  localparam int IDX_W    = 12;
  localparam int WORD_W   = 16;
  // Linear index reachable by a rectangle walk: 63 * 255 + 127 < 2**14
  localparam int LIN_W    = 14;
  // Compare width, wide enough to hold the largest map depth itself
  localparam int CMP_W    = 17;
  localparam int AREA_W   = COLS_W + ROWS_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b1;
  localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

  // Opcodes
  localparam logic [1:0] OP_INVALIDATE = 2'd0;
  localparam logic [1:0] OP_PRESENT    = 2'd1;
  localparam logic [1:0] OP_CLEAR      = 2'd2;

  // Dim mask clears both intensity bits
  localparam logic [WORD_W-1:0] DIM_MASK = 16'h77FF;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [COL_W-1:0] col_first;
    logic [ROW_W-1:0] row_first;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic [IDX_W-1:0] cell_index;
    logic [7:0]       char_code;
    logic [23:0]      fg_rgb;
    logic [23:0]      bg_rgb;
    logic             dim_flag;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  write_index;
    logic [WORD_W-1:0] cell_word;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RECT_SETUP,
    ST_RECT_WALK,
    ST_PRES_READ,
    ST_PRES_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // take the accepted beat
    logic clr_start;   // restart the clearing sweep
    logic clr_step;    // clear one entry
    logic rect_load;   // set up walk counters
    logic rect_step;   // mark one cell, advance
    logic pres_read;   // read dirty bit, build word
    logic pres_emit;   // load result, clear bit
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic rect_empty;
    logic rect_last;
    logic pres_in_range;
    logic pres_dirty;
    logic res_busy;
  } ctl_sts_t;

  // Colour to IRGB; low-saturation colours become one of four greys
  function automatic logic [3:0] to_irgb(input logic [23:0] rgb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [8:0] sum;
    logic [7:0] avg;
    logic [3:0] q;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (g < lo) lo = g;
    if (b > hi) hi = b;
    if (b < lo) lo = b;
    sum = {1'b0, hi} + {1'b0, lo};
    avg = sum[8:1];
    if ((hi - lo) < 8'h50) begin
      if (avg < 8'h40)       q = 4'h0;
      else if (avg <= 8'h80) q = 4'h8;
      else if (avg < 8'hC0)  q = 4'h7;
      else                   q = 4'hF;
    end else begin
      q = {hi >= 8'd192, r >= 8'h80, g >= 8'h80, b >= 8'h80};
    end
    return q;
  endfunction

endpackage

// File: design/tcdmr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcdmr_ctrl
// Sequencer: accepts one beat at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module tcdmr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic [1:0]          cmd_opcode,
  output logic                cmd_stall,
  input  tcdmr_pkg::ctl_sts_t sts,
  output tcdmr_pkg::ctl_cmd_t ctl
);

  tcdmr_pkg::state_t state;
  tcdmr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcdmr_pkg::ST_CLEAR;  // map swept clear after reset
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_stall  = 1'b1;
    case (state)
      tcdmr_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          ctl.capture = 1'b1;
          case (cmd_opcode)
            tcdmr_pkg::OP_INVALIDATE: state_next = tcdmr_pkg::ST_RECT_SETUP;
            tcdmr_pkg::OP_PRESENT:    state_next = tcdmr_pkg::ST_PRES_READ;
            tcdmr_pkg::OP_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = tcdmr_pkg::ST_CLEAR;
            end
            default: state_next = tcdmr_pkg::ST_IDLE;
          endcase
        end
      end
      tcdmr_pkg::ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = tcdmr_pkg::ST_IDLE;
      end
      tcdmr_pkg::ST_RECT_SETUP: begin
        if (sts.rect_empty) begin
          state_next = tcdmr_pkg::ST_IDLE;
        end else begin
          ctl.rect_load = 1'b1;
          state_next    = tcdmr_pkg::ST_RECT_WALK;
        end
      end
      tcdmr_pkg::ST_RECT_WALK: begin
        ctl.rect_step = 1'b1;
        if (sts.rect_last) state_next = tcdmr_pkg::ST_IDLE;
      end
      tcdmr_pkg::ST_PRES_READ: begin
        if (sts.pres_in_range) begin
          ctl.pres_read = 1'b1;
          state_next    = tcdmr_pkg::ST_PRES_EMIT;
        end else begin
          state_next = tcdmr_pkg::ST_IDLE;
        end
      end
      tcdmr_pkg::ST_PRES_EMIT: begin
        if (!sts.pres_dirty) begin
          state_next = tcdmr_pkg::ST_IDLE;
        end else if (!sts.res_busy) begin
          ctl.pres_emit = 1'b1;
          state_next    = tcdmr_pkg::ST_IDLE;
        end
      end
      default: state_next = tcdmr_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: design/tcdmr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcdmr_datapath
// Screen registers, dirty bit memory, rectangle walker, word builder and
// the result register.
// ----------------------------------------------------------------------------
module tcdmr_datapath #(
  parameter int MAX_CELLS = tcdmr_pkg::MAX_CELLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tcdmr_pkg::cmd_t                     cmd,
  input  logic                                cfg_write,
  input  logic [tcdmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcdmr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  tcdmr_pkg::ctl_cmd_t                 ctl,
  output tcdmr_pkg::ctl_sts_t                 sts,
  output logic                                res_valid,
  input  logic                                res_stall,
  output tcdmr_pkg::res_t                     res
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int CW = tcdmr_pkg::CMP_W;

  // Screen size
  logic [tcdmr_pkg::COLS_W-1:0] cols;
  logic [tcdmr_pkg::ROWS_W-1:0] rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= tcdmr_pkg::COLS_RESET;
      rows <= tcdmr_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tcdmr_pkg::CFG_SCREEN_COLS: cols <= cfg_data;
        tcdmr_pkg::CFG_SCREEN_ROWS: rows <= cfg_data[tcdmr_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured beat
  tcdmr_pkg::cmd_t cmd_q;

  always_ff @(posedge clk) begin
    if (ctl.capture) cmd_q <= cmd;
  end

  // Clearing sweep counter
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_start) begin
      clr_cnt <= '0;
    end else if (ctl.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign sts.clr_last = (clr_cnt == AW'(MAX_CELLS - 1));

  // Rectangle walk
  logic [tcdmr_pkg::COL_W-1:0] x;
  logic [tcdmr_pkg::COL_W-1:0] x_last;
  logic [tcdmr_pkg::ROW_W-1:0] y;
  logic [tcdmr_pkg::ROW_W-1:0] y_last;
  logic [tcdmr_pkg::LIN_W-1:0] row_base;
  logic [tcdmr_pkg::LIN_W-1:0] lin;
  logic [CW-1:0]               lin_ext;
  logic                        lin_ok;
  logic [tcdmr_pkg::COLS_W-1:0] cols_m1;
  logic [tcdmr_pkg::ROWS_W-1:0] rows_m1;

  assign cols_m1 = cols - tcdmr_pkg::COLS_W'(1);
  assign rows_m1 = rows - tcdmr_pkg::ROWS_W'(1);

  assign sts.rect_empty = (cmd_q.col_first > cmd_q.col_last) ||
                          (cmd_q.row_first > cmd_q.row_last) ||
                          ({1'b0, cmd_q.col_first} >= cols) ||
                          ({1'b0, cmd_q.row_first} >= rows);

  always_ff @(posedge clk) begin
    if (ctl.rect_load) begin
      x        <= cmd_q.col_first;
      y        <= cmd_q.row_first;
      row_base <= tcdmr_pkg::LIN_W'(cmd_q.row_first) * tcdmr_pkg::LIN_W'(cols);
      x_last   <= ({1'b0, cmd_q.col_last} < cols) ? cmd_q.col_last
                                                   : cols_m1[tcdmr_pkg::COL_W-1:0];
      y_last   <= ({1'b0, cmd_q.row_last} < rows) ? cmd_q.row_last
                                                   : rows_m1[tcdmr_pkg::ROW_W-1:0];
    end else if (ctl.rect_step) begin
      if (x == x_last) begin
        x        <= cmd_q.col_first;
        y        <= y + tcdmr_pkg::ROW_W'(1);
        row_base <= row_base + tcdmr_pkg::LIN_W'(cols);
      end else begin
        x <= x + tcdmr_pkg::COL_W'(1);
      end
    end
  end

  assign lin           = row_base + tcdmr_pkg::LIN_W'(x);
  assign lin_ext       = CW'(lin);
  assign lin_ok        = (lin_ext < CW'(MAX_CELLS));
  assign sts.rect_last = (x == x_last) && (y == y_last);

  // Present: range check and word build
  logic [tcdmr_pkg::AREA_W-1:0] area;
  logic [CW-1:0]                cidx_ext;
  logic [tcdmr_pkg::WORD_W-1:0] word_raw;
  logic [tcdmr_pkg::WORD_W-1:0] word_q;

  assign area     = tcdmr_pkg::AREA_W'(cols) * tcdmr_pkg::AREA_W'(rows);
  assign cidx_ext = CW'(cmd_q.cell_index);
  assign sts.pres_in_range = (cidx_ext < CW'(area)) && (cidx_ext < CW'(MAX_CELLS));

  assign word_raw = {tcdmr_pkg::to_irgb(cmd_q.bg_rgb),
                     tcdmr_pkg::to_irgb(cmd_q.fg_rgb),
                     cmd_q.char_code};

  always_ff @(posedge clk) begin
    if (ctl.pres_read) begin
      word_q <= cmd_q.dim_flag ? (word_raw & tcdmr_pkg::DIM_MASK) : word_raw;
    end
  end

  // Dirty bit memory
  logic          mem [MAX_CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wbit;
  logic          rd_bit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt;
    mem_wbit  = 1'b0;
    if (ctl.clr_step) begin
      mem_we = 1'b1;
    end else if (ctl.rect_step) begin
      mem_we    = lin_ok;
      mem_waddr = lin_ext[AW-1:0];
      mem_wbit  = 1'b1;
    end else if (ctl.pres_emit) begin
      mem_we    = 1'b1;
      mem_waddr = cidx_ext[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wbit;
    if (ctl.pres_read) rd_bit <= mem[cidx_ext[AW-1:0]];
  end

  assign sts.pres_dirty = rd_bit;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.pres_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pres_emit) begin
      res.write_index <= cmd_q.cell_index;
      res.cell_word   <= word_q;
    end
  end

  assign sts.res_busy = res_valid && res_stall;

endmodule

// File: design/text_cell_dirty_map_renderer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_dirty_map_renderer_unit
// Dirty map over a text screen; emits text words for dirty cells.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  cmd     | cmd_valid / cmd_stall  | tcdmr_pkg::cmd_t (opcode, rect, cell)
//  res     | res_valid / res_stall  | tcdmr_pkg::res_t (write_index, word)
//  cfg     | cfg_write              | cfg_index, cfg_data (cols, rows)
//
// One beat is in work at a time; the sequencer holds cmd_stall high until
// it is done. Present: accept, dirty bit read, emit; the emit waits while
// the result register stays stalled. Invalidate: accept, setup, then one
// on-screen cell per cycle, the single memory write port setting the pace.
// Clear: one entry per cycle over all MAX_CELLS entries.
// After rst (synchronous, active high) a clearing pass over all MAX_CELLS
// entries runs with cmd_stall high; config writes are taken throughout.
// The result register lets a new beat in while a result waits to be taken.
// ----------------------------------------------------------------------------
module text_cell_dirty_map_renderer_unit #(
  parameter int MAX_CELLS = tcdmr_pkg::MAX_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // command channel
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  tcdmr_pkg::cmd_t                  cmd,
  // result channel
  output logic                             res_valid,
  input  logic                             res_stall,
  output tcdmr_pkg::res_t                  res,
  // configuration
  input  logic                             cfg_write,
  input  logic [tcdmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcdmr_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcdmr_pkg::ctl_cmd_t ctl;
  tcdmr_pkg::ctl_sts_t sts;

  // sequencer: one beat at a time
  tcdmr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_opcode (cmd.opcode),
    .cmd_stall  (cmd_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  // storage, walker, quantizers and result register
  tcdmr_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
